// ===== hw/rtl/cie_pkg.sv =====
`timescale 1ns / 1ps

package cie_pkg;

  // Base instruction major opcodes.
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_JAL    = 7'h6f;

  localparam logic [6:0]  FN7_SUB     = 7'h20;
  localparam logic [6:0]  FN7_SRA     = 7'h20;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_LW   = 3'd2;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRX  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_RA   = 5'd1;
  localparam logic [4:0] REG_SP   = 5'd2;

  // Compressed form selector: {quadrant, funct3}.
  localparam logic [4:0] CF_ADDI4SPN = 5'h00;
  localparam logic [4:0] CF_LW       = 5'h02;
  localparam logic [4:0] CF_SW       = 5'h06;
  localparam logic [4:0] CF_ADDI     = 5'h08;
  localparam logic [4:0] CF_JAL      = 5'h09;
  localparam logic [4:0] CF_LI       = 5'h0a;
  localparam logic [4:0] CF_LUI      = 5'h0b;
  localparam logic [4:0] CF_ALU      = 5'h0c;
  localparam logic [4:0] CF_J        = 5'h0d;
  localparam logic [4:0] CF_BEQZ     = 5'h0e;
  localparam logic [4:0] CF_BNEZ     = 5'h0f;
  localparam logic [4:0] CF_SLLI     = 5'h10;
  localparam logic [4:0] CF_LWSP     = 5'h12;
  localparam logic [4:0] CF_JR_ADD   = 5'h14;
  localparam logic [4:0] CF_SWSP     = 5'h16;

  // Sub-selector of the register arithmetic group, instr16[11:10].
  localparam logic [1:0] ALU_SRLI = 2'd0;
  localparam logic [1:0] ALU_SRAI = 2'd1;
  localparam logic [1:0] ALU_ANDI = 2'd2;
  localparam logic [1:0] ALU_REG  = 2'd3;

  // Register-register group selector, instr16[6:5].
  localparam logic [1:0] ARITH_SUB = 2'd0;
  localparam logic [1:0] ARITH_XOR = 2'd1;
  localparam logic [1:0] ARITH_OR  = 2'd2;
  localparam logic [1:0] ARITH_AND = 2'd3;

  typedef struct packed {
    logic        ok;
    logic [31:0] word;
  } exp_result_t;

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                        input logic [2:0] f3, input logic [4:0] rd,
                                        input logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OP_REG};
  endfunction

  function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                        input logic [4:0] rs1);
    return {imm[11:5], rs2, rs1, F3_LW, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs1,
                                        input logic [2:0] f3);
    return {imm[12], imm[10:5], REG_ZERO, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  function automatic exp_result_t expand(input logic [15:0] c);
    exp_result_t r;
    logic [4:0]  rd;
    logic [4:0]  rs2;
    logic [4:0]  rdp;
    logic [4:0]  rs1p;
    logic        b12;
    logic [5:0]  imm6;
    logic [11:0] simm6;
    logic [9:0]  t10;
    logic [11:0] t12;
    logic [8:0]  t9;
    logic [6:0]  t7;
    logic [7:0]  t8;
    logic [2:0]  f3r;
    rd    = c[11:7];
    rs2   = c[6:2];
    rdp   = {2'b01, c[4:2]};
    rs1p  = {2'b01, c[9:7]};
    b12   = c[12];
    imm6  = {b12, rs2};
    simm6 = {{6{imm6[5]}}, imm6};
    r.ok   = 1'b1;
    r.word = '0;
    case ({c[1:0], c[15:13]})
      CF_ADDI4SPN: begin
        t10 = {c[10:7], c[12:11], c[5], c[6], 2'b00};
        r.ok = (t10 != '0);
        r.word = enc_i({2'b00, t10}, REG_SP, F3_ADD, rdp, OP_IMM);
      end
      CF_LW, CF_SW: begin
        t7 = {c[5], c[12:10], c[6], 2'b00};
        r.word = (c[15:13] == F3_LW) ? enc_i({5'b0, t7}, rs1p, F3_LW, rdp, OP_LOAD)
                                     : enc_s({5'b0, t7}, rdp, rs1p);
      end
      CF_ADDI: begin
        if (rd == REG_ZERO && imm6 == '0) begin
          r.word = {25'b0, OP_IMM};
        end else begin
          r.ok = (rd != REG_ZERO) && (imm6 != '0);
          r.word = enc_i(simm6, rd, F3_ADD, rd, OP_IMM);
        end
      end
      CF_JAL, CF_J: begin
        t12 = {b12, c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0};
        r.word = enc_j({{9{t12[11]}}, t12}, (c[15:13] == CF_JAL[2:0]) ? REG_RA : REG_ZERO);
      end
      CF_LI: begin
        r.ok = (rd != REG_ZERO);
        r.word = enc_i(simm6, REG_ZERO, F3_ADD, rd, OP_IMM);
      end
      CF_LUI: begin
        if (rd == REG_SP) begin
          t10 = {b12, c[4:3], c[5], c[2], c[6], 4'b0000};
          r.ok = (t10 != '0);
          r.word = enc_i({{2{t10[9]}}, t10}, REG_SP, F3_ADD, REG_SP, OP_IMM);
        end else begin
          r.ok = (rd != REG_ZERO) && (imm6 != '0);
          r.word = {{14{imm6[5]}}, imm6, rd, OP_LUI};
        end
      end
      CF_ALU: begin
        case (c[11:10])
          ALU_SRLI, ALU_SRAI: begin
            r.ok = !b12 && (rs2 != '0);
            r.word = enc_i({(c[10] ? FN7_SRA : 7'h00), rs2}, rs1p, F3_SRX, rs1p, OP_IMM);
          end
          ALU_ANDI: begin
            r.word = enc_i(simm6, rs1p, F3_AND, rs1p, OP_IMM);
          end
          default: begin
            case (c[6:5])
              ARITH_SUB: f3r = F3_ADD;
              ARITH_XOR: f3r = F3_XOR;
              ARITH_OR:  f3r = F3_OR;
              default:   f3r = F3_AND;
            endcase
            r.ok = !b12;
            r.word = enc_r((c[6:5] == ARITH_SUB) ? FN7_SUB : 7'h00, rdp, rs1p, f3r, rs1p);
          end
        endcase
      end
      CF_BEQZ, CF_BNEZ: begin
        t9 = {b12, c[6:5], c[2], c[11:10], c[4:3], 1'b0};
        r.word = enc_b({{4{t9[8]}}, t9}, rs1p, {2'b00, c[13]});
      end
      CF_SLLI: begin
        r.ok = !b12 && (rs2 != '0) && (rd != REG_ZERO);
        r.word = enc_i({7'b0, rs2}, rd, F3_SLL, rd, OP_IMM);
      end
      CF_LWSP: begin
        t8 = {c[3:2], b12, c[6:4], 2'b00};
        r.ok = (rd != REG_ZERO);
        r.word = enc_i({4'b0, t8}, REG_SP, F3_LW, rd, OP_LOAD);
      end
      CF_JR_ADD: begin
        if (rs2 == '0) begin
          if (rd == REG_ZERO) begin
            r.ok = b12;
            r.word = WORD_EBREAK;
          end else begin
            r.word = enc_i(12'h000, rd, F3_ADD, {4'b0, b12}, OP_JALR);
          end
        end else begin
          r.ok = (rd != REG_ZERO);
          r.word = enc_r(7'h00, rs2, b12 ? rd : REG_ZERO, F3_ADD, rd);
        end
      end
      CF_SWSP: begin
        t8 = {c[8:7], c[12:9], 2'b00};
        r.word = enc_s({4'b0, t8}, rs2, REG_SP);
      end
      default: begin
        r.ok = 1'b0;
      end
    endcase
    if (!r.ok) begin
      r.word = '0;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/compressed_instruction_expander_unit.sv =====
`timescale 1ns / 1ps
// Path: an accepted word passes the input register, then one combinational expansion
// stage, then the result register that drives the output.
// Throughput: one word per cycle, set by the single combinational expansion stage;
// backpressure from the output stalls both registers.
// Reset (synchronous, rst high) clears both valid flags; data registers are not reset.
module compressed_instruction_expander_unit
  import cie_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] instr16
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] instr32
  output logic        m_axis_tuser    // [0] recognized
);

  logic        s1_valid;
  logic [15:0] s1_instr;
  exp_result_t s1_result;
  exp_result_t result;
  logic        out_load;
  logic        in_load;

  assign out_load      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !s1_valid || out_load;
  assign in_load       = s_axis_tvalid && s_axis_tready;
  assign s1_result     = expand(s1_instr);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
    if (in_load) begin
      s1_instr <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= s1_valid;
    end
    if (out_load && s1_valid) begin
      result <= s1_result;
    end
  end

  assign m_axis_tdata = result.word;
  assign m_axis_tuser = result.ok;

`ifndef SYNTH
  a_unrec_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 32'h0))
    else $error("unrecognized word carries nonzero data");

  a_rec_wide: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[1:0] == 2'b11))
    else $error("recognized word is not a 32-bit encoding");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> s1_valid)
    else $error("accepted word lost at input register");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready && s1_valid) |-> !s_axis_tready)
    else $error("input taken while pipeline is full and stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && !s1_valid))
    else $error("valid flags not cleared by reset");
`endif

endmodule
